>>> hdl/brc_pkg.sv
// ----------------------------------------------------------------------------
// brc_pkg: shared types and constants for the byte range coalescer
// Field widths, cell chain depth and the cell-to-cell bus.
// ----------------------------------------------------------------------------
package brc_pkg;

  localparam int MaxRequests = 32;
  localparam int CntW        = $clog2(MaxRequests + 1);
  localparam int IdxW        = $clog2(MaxRequests);
  localparam int AddrW       = 40;
  localparam int LenW        = 32;
  localparam int IdW         = 16;
  localparam int GapW        = 32;
  localparam int IcntW       = 17;
  localparam int CfgW        = 40;
  localparam int CfgIdxW     = 2;

  localparam logic [CfgIdxW-1:0] RegDataOffset  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCoalesceGap = 2'd1;
  localparam logic [CfgIdxW-1:0] RegIndexCount  = 2'd2;

  localparam logic [AddrW-1:0] AddrMax = {AddrW{1'b1}};

  typedef struct packed {
    logic [AddrW-1:0] start;
    logic [LenW-1:0]  len;
    logic [IdW-1:0]   id;
  } span_t;

  // what the cell to the left tells its neighbour
  typedef struct packed {
    logic  valid;  // left cell holds a span
    logic  less;   // new span sorts before the left cell's span
    span_t span;   // left cell's span
  } link_t;

  function automatic logic [AddrW-1:0] sat_add(input logic [AddrW-1:0] a,
                                               input logic [AddrW-1:0] b);
    logic [AddrW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AddrW] ? AddrMax : s[AddrW-1:0];
  endfunction

endpackage

>>> hdl/brc_cell.sv
// ----------------------------------------------------------------------------
// brc_cell: one slot of the sorted span chain
// Holds one span. On insert it keeps its span, takes the new span, or takes
// the left neighbour's span. On shift it takes the right neighbour's span
// (drain).
// ----------------------------------------------------------------------------
module brc_cell
  import brc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  ins,       // insert the new span this cycle
  input  logic  clr,       // empty the chain
  input  logic  shift,     // drain: take the right neighbour's span
  input  span_t new_span,
  input  link_t left,
  input  link_t right,
  output link_t self,
  output logic  dup        // holds the same id as the new span
);

  logic  valid;
  span_t span;
  logic  less;

  always_comb begin
    if (new_span.start != span.start)   less = new_span.start < span.start;
    else if (new_span.len != span.len)  less = new_span.len < span.len;
    else                                less = new_span.id < span.id;
  end

  assign self.valid = valid;
  assign self.less  = valid & less;
  assign self.span  = span;
  assign dup        = valid && (span.id == new_span.id);

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= right.valid;
      span  <= right.span;
    end else if (ins) begin
      // sorted chain: cells with less set form a suffix of the valid ones;
      // only the first empty cell (valid left neighbour) fills
      if (!valid) begin
        if (left.valid) begin
          valid <= 1'b1;
          span  <= left.less ? left.span : new_span;
        end
      end else if (less) begin
        span <= left.less ? left.span : new_span;
      end
    end
  end

endmodule

>>> hdl/brc_chain.sv
// ----------------------------------------------------------------------------
// brc_chain: row of sorted span cells
// Inserts one span a cycle in order; drains from the head one a cycle.
// ----------------------------------------------------------------------------
module brc_chain
  import brc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  ins,
  input  logic  clr,
  input  logic  shift,
  input  span_t new_span,
  output logic  any_dup,
  output span_t head_span
);

  link_t links [MaxRequests];
  logic [MaxRequests-1:0] dups;

  for (genvar g = 0; g < MaxRequests; g++) begin : g_cell
    link_t lt, rt;
    if (g == 0) begin : g_first
      // head sees a held, not-smaller neighbour: takes the new span when empty
      assign lt = '{valid: 1'b1, less: 1'b0, span: '0};
    end else begin : g_mid
      assign lt = links[g-1];
    end
    if (g == MaxRequests - 1) begin : g_tail
      assign rt = '0;
    end else begin : g_body
      assign rt = links[g+1];
    end
    brc_cell u_cell (
      .clk, .rst, .ins, .clr, .shift, .new_span,
      .left(lt), .right(rt), .self(links[g]), .dup(dups[g])
    );
  end

  assign any_dup   = |dups;
  assign head_span = links[0].span;

endmodule

>>> hdl/byte_range_coalescer.sv
// ----------------------------------------------------------------------------
// byte_range_coalescer: coalesced read planning for a batch of block requests
// Sorted insertion into a chain of cells, then a plan pass and an emit pass.
// ----------------------------------------------------------------------------
// channel   dir  handshake              payload
// s_axis    in   s_axis_tvalid/tready   request item, tuser = constant,
//                                       tlast = last_request
// m_axis    out  m_axis_tvalid/tready   result item, tlast = run_done
// cfg       in   cfg_we                 cfg_index, cfg_data
//
// Fill: one request item a cycle, every cell compares and shifts at once.
// After the last item the chain head drains to the plan buffer, one entry
// per kept span; then results leave one a cycle while the output is ready.
// An empty batch stays in fill. Input is held off from the last item until
// the final result is taken; a stalled result holds the emit walk.
// Reset (rst, synchronous) empties the chain and restores the registers.
// ----------------------------------------------------------------------------
module byte_range_coalescer
  import brc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata: block_id[15:0], entry_offset[55:16], entry_length[87:56]
  input  logic [87:0]          s_axis_tdata,
  // tuser: entry_is_constant[0]
  input  logic                 s_axis_tuser,
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tdata: plan_start[39:0], plan_length[79:40], useful_bytes[119:80],
  //        out_block_id[135:120], plan_done[136], capacity_exceeded[137],
  //        zero pad to 144
  output logic [143:0]         m_axis_tdata,
  output logic                 m_axis_tlast,
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [CfgW-1:0]      cfg_data
);

  typedef enum logic [2:0] {
    ST_FILL = 3'b001,
    ST_PLAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state;

  logic [AddrW-1:0] data_offset;
  logic [GapW-1:0]  coalesce_gap;
  logic [IcntW-1:0] index_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_offset  <= '0;
      coalesce_gap <= '0;
      index_count  <= IcntW'(65536);
    end else if (cfg_we) begin
      case (cfg_index)
        RegDataOffset:  data_offset  <= cfg_data[AddrW-1:0];
        RegCoalesceGap: coalesce_gap <= cfg_data[GapW-1:0];
        RegIndexCount:  index_count  <= cfg_data[IcntW-1:0];
        default: ;
      endcase
    end
  end

  // request fields
  logic [IdW-1:0]   in_id;
  logic [AddrW-1:0] in_off;
  logic [LenW-1:0]  in_len;
  logic             in_cst;
  assign in_id  = s_axis_tdata[15:0];
  assign in_off = s_axis_tdata[55:16];
  assign in_len = s_axis_tdata[87:56];
  assign in_cst = s_axis_tuser;

  span_t new_span, head_span;
  logic  any_dup, ins, clr, shift;
  logic  in_acc, keep, room;

  logic [CntW-1:0] kept_count, walk;
  logic            overflow_seen;

  assign s_axis_tready = (state == ST_FILL);
  assign in_acc = s_axis_tvalid & s_axis_tready;
  assign room   = kept_count < CntW'(MaxRequests);
  // valid id, owns bytes, not already kept this batch
  assign keep   = ({1'b0, in_id} < index_count) && !in_cst && (in_len != '0) && !any_dup;

  assign new_span.start = sat_add(data_offset, in_off);
  assign new_span.len   = in_len;
  assign new_span.id    = in_id;

  assign ins   = (state == ST_FILL) && in_acc && keep && room;
  assign shift = (state == ST_PLAN);
  assign clr   = 1'b0;

  // plan pass: the head drains one span a cycle in sorted order; ids go to
  // a slot buffer, running plan values are kept at the plan's first slot
  logic [AddrW-1:0] ps, pe, useful;
  logic [AddrW-1:0] h_end;
  logic [AddrW:0]   reach;
  logic             join_p;
  logic [IdxW-1:0]  w_idx, plan_first_w, plan_idx;
  logic [AddrW-1:0] ps_n, pe_n, use_n;
  logic [IdW-1:0]   buf_id    [MaxRequests];
  logic [IdxW-1:0]  slot_plan [MaxRequests];
  logic [AddrW-1:0] plan_ps   [MaxRequests];
  logic [AddrW-1:0] plan_pe   [MaxRequests];
  logic [AddrW-1:0] plan_use  [MaxRequests];
  logic [MaxRequests-1:0] first_of_plan;

  assign w_idx  = walk[IdxW-1:0];
  assign h_end  = sat_add(head_span.start, {{(AddrW-LenW){1'b0}}, head_span.len});
  assign reach  = {1'b0, pe} + {{(AddrW-GapW+1){1'b0}}, coalesce_gap};
  assign join_p = (walk != '0) && ({1'b0, head_span.start} <= reach);
  assign plan_idx = join_p ? plan_first_w : w_idx;

  always_comb begin
    if (join_p) begin
      ps_n  = ps;
      pe_n  = (h_end > pe) ? h_end : pe;
      use_n = sat_add(useful, {{(AddrW-LenW){1'b0}}, head_span.len});
    end else begin
      ps_n  = head_span.start;
      pe_n  = h_end;
      use_n = {{(AddrW-LenW){1'b0}}, head_span.len};
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PLAN) begin
      ps     <= ps_n;
      pe     <= pe_n;
      useful <= use_n;
      if (!join_p) plan_first_w <= w_idx;
      buf_id[w_idx]        <= head_span.id;
      first_of_plan[w_idx] <= !join_p;
      slot_plan[w_idx]     <= plan_idx;
      plan_ps[plan_idx]    <= ps_n;
      plan_pe[plan_idx]    <= pe_n;
      plan_use[plan_idx]   <= use_n;
    end
  end

  // emit side
  logic             out_v, out_adv;
  logic [IdxW-1:0]  e_pl;
  logic [CntW-1:0]  nxt;
  logic [AddrW-1:0] o_ps, o_pe, o_use, o_plen;
  logic [IdW-1:0]   o_id;
  logic             o_last, o_pdone;

  assign out_adv = !out_v || m_axis_tready;
  assign e_pl    = slot_plan[w_idx];
  assign nxt     = walk + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_FILL;
      kept_count    <= '0;
      overflow_seen <= 1'b0;
      walk          <= '0;
      out_v         <= 1'b0;
    end else begin
      case (state)
        ST_FILL: begin
          if (in_acc) begin
            if (s_axis_tlast && (kept_count == '0) && !ins) begin
              // empty batch: nothing to plan
              overflow_seen <= 1'b0;
            end else begin
              if (keep && !room) overflow_seen <= 1'b1;
              if (ins) kept_count <= kept_count + 1'b1;
              if (s_axis_tlast) begin
                walk  <= '0;
                state <= ST_PLAN;
              end
            end
          end
        end
        ST_PLAN: begin
          if (nxt == kept_count) begin
            walk  <= '0;
            state <= ST_EMIT;
          end else begin
            walk <= nxt;
          end
        end
        ST_EMIT: begin
          if (out_adv) begin
            if (walk == kept_count) begin
              out_v         <= 1'b0;
              state         <= ST_FILL;
              kept_count    <= '0;
              overflow_seen <= 1'b0;
            end else begin
              out_v <= 1'b1;
              walk  <= nxt;
            end
          end
        end
        default: state <= ST_FILL;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && out_adv && (walk != kept_count)) begin
      o_ps    <= plan_ps[e_pl];
      o_pe    <= plan_pe[e_pl];
      o_use   <= plan_use[e_pl];
      o_id    <= buf_id[w_idx];
      o_last  <= (nxt == kept_count);
      o_pdone <= (nxt == kept_count) || first_of_plan[nxt[IdxW-1:0]];
    end
  end

  assign o_plen = o_pe - o_ps;

  assign m_axis_tvalid = out_v;
  assign m_axis_tlast  = o_last;
  assign m_axis_tdata  = {6'd0, overflow_seen, o_pdone, o_id, o_use, o_plen, o_ps};

  brc_chain u_chain (
    .clk, .rst, .ins, .clr, .shift, .new_span,
    .any_dup, .head_span
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    kept_count <= CntW'(MaxRequests)) else $error("kept count overrun");
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_FILL) |-> !s_axis_tready) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_v && !m_axis_tready) |=> out_v) else $error("result lost");
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_v && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("result changed while stalled");

endmodule
